[sv/cle_pkg.sv]
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants for the cursor line editor: command codes,
// decoded operations, payload structs and the back-end state encoding.
// ----------------------------------------------------------------------------
package cle_pkg;

   // default text capacity in characters
   localparam int CAPACITY_DEFAULT = 64;

   // depth of the command queue between front and back end (power of two)
   localparam int QUEUE_DEPTH = 4;

   // command codes on the request channel
   localparam logic [2:0] KIND_LEFT   = 3'd0;
   localparam logic [2:0] KIND_RIGHT  = 3'd1;
   localparam logic [2:0] KIND_BACK   = 3'd2;
   localparam logic [2:0] KIND_INSERT = 3'd3;
   localparam logic [2:0] KIND_DUMP   = 3'd4;

   // decoded operation carried through the queue
   typedef enum logic [2:0] {
      OP_LEFT,
      OP_RIGHT,
      OP_BACK,
      OP_INSERT,
      OP_DUMP
   } op_type;

   // request item
   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] symbol;
   } req_type;

   // result item
   typedef struct packed {
      logic [7:0] text_char;
      logic       nonempty;
      logic       last;
   } rsp_type;

   // decoded command
   typedef struct packed {
      op_type     op;
      logic [7:0] symbol;
   } cmd_type;

   // command together with its qualifier, used on both sides of the queue
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_slot_type;

   // back-end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOVE_L,
      ST_MOVE_R,
      ST_DUMP
   } back_state_type;

endpackage

[sv/cle_ram.sv]
// ----------------------------------------------------------------------------
// cle_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/cle_front.sv]
// ----------------------------------------------------------------------------
// cle_front
// Front end: takes command items, decodes the kind code into an operation
// and drops the codes that mean nothing.
// ----------------------------------------------------------------------------
module cle_front import cle_pkg::*; (
   input  logic         accept,
   input  req_type      req_data,
   output cmd_slot_type push
);

   // decode the kind field
   always_comb begin
      push.valid      = 1'b0;
      push.cmd.op     = OP_LEFT;
      push.cmd.symbol = req_data.symbol;
      case (req_data.kind)
         KIND_LEFT: begin
            push.valid  = accept;
            push.cmd.op = OP_LEFT;
         end
         KIND_RIGHT: begin
            push.valid  = accept;
            push.cmd.op = OP_RIGHT;
         end
         KIND_BACK: begin
            push.valid  = accept;
            push.cmd.op = OP_BACK;
         end
         KIND_INSERT: begin
            push.valid  = accept;
            push.cmd.op = OP_INSERT;
         end
         KIND_DUMP: begin
            push.valid  = accept;
            push.cmd.op = OP_DUMP;
         end
         default: begin
            push.valid = 1'b0;
         end
      endcase
   end

endmodule

[sv/cle_queue.sv]
// ----------------------------------------------------------------------------
// cle_queue
// Small command FIFO between the front and the back end.
// ----------------------------------------------------------------------------
module cle_queue import cle_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_slot_type push,
   input  logic         pop,
   output cmd_slot_type head,
   output logic         full
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]   head_ff, head_in;
   logic [PW-1:0]   tail_ff, tail_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == CW'(QUEUE_DEPTH));
   assign do_push = push.valid && !full;
   assign do_pop  = pop && (count_ff != '0);

   // pointer and fill count update
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = tail_ff + PW'(1);
      end
      if (do_pop) begin
         head_in = head_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[tail_ff] <= push.cmd;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[head_ff];

endmodule

[sv/cle_back.sv]
// ----------------------------------------------------------------------------
// cle_back
// Back end: carries out commands on the two character stacks and streams
// the text during a dump.
// ----------------------------------------------------------------------------
module cle_back import cle_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  cmd_slot_type head,
   output logic         pop,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   back_state_type state_ff, state_in;
   logic [CW-1:0]  lcount_ff, lcount_in;
   logic [CW-1:0]  rcount_ff, rcount_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic           pend_ff, pend_in;
   logic           empty_ff, empty_in;
   logic           last_ff, last_in;
   logic           src_r_ff, src_r_in;
   logic [CW-1:0]  total;
   logic [CW-1:0]  rev_idx;

   logic           l_we, r_we;
   logic [AW-1:0]  l_waddr, r_waddr, l_raddr, r_raddr;
   logic [7:0]     l_wdata, r_wdata, l_rdata, r_rdata;

   assign total   = lcount_ff + rcount_ff;
   assign rev_idx = total - CW'(1) - idx_ff;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      lcount_in = lcount_ff;
      rcount_in = rcount_ff;
      idx_in    = idx_ff;
      pend_in   = 1'b0;
      empty_in  = 1'b0;
      last_in   = 1'b0;
      src_r_in  = 1'b0;
      pop       = 1'b0;
      l_we      = 1'b0;
      r_we      = 1'b0;
      l_waddr   = lcount_ff[AW-1:0];
      r_waddr   = rcount_ff[AW-1:0];
      l_wdata   = head.cmd.symbol;
      r_wdata   = l_rdata;
      l_raddr   = '0;
      r_raddr   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               case (head.cmd.op)
                  OP_LEFT: begin
                     if (lcount_ff != '0 && rcount_ff != CW'(CAPACITY)) begin
                        l_raddr  = AW'(lcount_ff - CW'(1));
                        state_in = ST_MOVE_L;
                     end
                  end
                  OP_RIGHT: begin
                     if (rcount_ff != '0 && lcount_ff != CW'(CAPACITY)) begin
                        r_raddr  = AW'(rcount_ff - CW'(1));
                        state_in = ST_MOVE_R;
                     end
                  end
                  OP_BACK: begin
                     if (lcount_ff != '0) begin
                        lcount_in = lcount_ff - CW'(1);
                     end
                  end
                  OP_INSERT: begin
                     // dropped when the buffer is full
                     if (total != CW'(CAPACITY)) begin
                        l_we      = 1'b1;
                        lcount_in = lcount_ff + CW'(1);
                     end
                  end
                  OP_DUMP: begin
                     if (total == '0) begin
                        pend_in  = 1'b1;
                        empty_in = 1'b1;
                        last_in  = 1'b1;
                     end else begin
                        idx_in   = '0;
                        state_in = ST_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MOVE_L: begin
            // left top arrives from the read register, push it on the right
            r_we      = 1'b1;
            r_wdata   = l_rdata;
            lcount_in = lcount_ff - CW'(1);
            rcount_in = rcount_ff + CW'(1);
            state_in  = ST_IDLE;
         end
         ST_MOVE_R: begin
            l_we      = 1'b1;
            l_wdata   = r_rdata;
            rcount_in = rcount_ff - CW'(1);
            lcount_in = lcount_ff + CW'(1);
            state_in  = ST_IDLE;
         end
         ST_DUMP: begin
            // left stack bottom first, then right stack top first
            pend_in = 1'b1;
            if (idx_ff < lcount_ff) begin
               l_raddr  = idx_ff[AW-1:0];
               src_r_in = 1'b0;
            end else begin
               r_raddr  = rev_idx[AW-1:0];
               src_r_in = 1'b1;
            end
            if (idx_ff == total - CW'(1)) begin
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         lcount_ff <= '0;
         rcount_ff <= '0;
         idx_ff    <= '0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         lcount_ff <= lcount_in;
         rcount_ff <= rcount_in;
         idx_ff    <= idx_in;
         pend_ff   <= pend_in;
      end
   end

   // result qualifiers travel alongside the ram read
   always_ff @(posedge clock) begin
      empty_ff <= empty_in;
      last_ff  <= last_in;
      src_r_ff <= src_r_in;
   end

   cle_ram #(
      .WIDTH (8),
      .DEPTH (CAPACITY)
   ) u_left_ram (
      .clock   (clock),
      .wr_en   (l_we),
      .wr_addr (l_waddr),
      .wr_data (l_wdata),
      .rd_addr (l_raddr),
      .rd_data (l_rdata)
   );

   cle_ram #(
      .WIDTH (8),
      .DEPTH (CAPACITY)
   ) u_right_ram (
      .clock   (clock),
      .wr_en   (r_we),
      .wr_addr (r_waddr),
      .wr_data (r_wdata),
      .rd_addr (r_raddr),
      .rd_data (r_rdata)
   );

   // result item
   assign rsp_strobe         = pend_ff;
   assign rsp_data.text_char = empty_ff ? 8'd0 : (src_r_ff ? r_rdata : l_rdata);
   assign rsp_data.nonempty  = !empty_ff;
   assign rsp_data.last      = last_ff;

endmodule

[sv/cursor_line_editor.sv]
// ----------------------------------------------------------------------------
// cursor_line_editor
// Line-editing buffer with a cursor, kept as a left and a right stack.
// ----------------------------------------------------------------------------
// A command item is taken when start is high and busy is low; busy rises only
// while the four-entry command queue is full (and during reset). Kind codes 5
// to 7 are dropped at the front and never enter the queue. Commands run in
// order in the back end: backspace, insert and a move at an end complete as
// they leave the queue, a move does a registered read of one stack RAM, then
// a write to the other, and a dump reads out the text character by character.
// Dump results appear on rsp_data for one cycle each, marked by rsp_strobe,
// one per cycle in text order; the first strobe follows the ST_DUMP state and
// the registered RAM read (for an empty text, only the result register). The
// receiver cannot hold results off and must take every strobe.
// ----------------------------------------------------------------------------
module cursor_line_editor import cle_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   cmd_slot_type push;
   cmd_slot_type head;
   logic         pop;
   logic         q_full;

   assign busy = reset || q_full;

   cle_front u_front (
      .accept   (start && !busy),
      .req_data (req_data),
      .push     (push)
   );

   cle_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (q_full)
   );

   cle_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

[sv/cle_checker.sv]
// ----------------------------------------------------------------------------
// cle_checker
// Port-level checks on the result stream of the cursor line editor.
// ----------------------------------------------------------------------------
module cle_checker import cle_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe after reset");

   // an empty-text result is a dump on its own
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.nonempty |-> rsp_data.last)
      else $error("empty result not marked last");

   // empty result carries a zero character
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.nonempty |-> rsp_data.text_char == 8'd0)
      else $error("empty result with nonzero character");

   // a dump streams without gaps until its last character
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |=> rsp_strobe && rsp_data.nonempty)
      else $error("dump stream broken before last");

   // busy during reset keeps commands out
   assert property (@(posedge clock) reset |-> busy)
      else $error("busy low during reset");

endmodule

bind cursor_line_editor cle_checker u_cle_checker (
   .clock      (clock),
   .reset      (reset),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

[sim/cursor_line_editor_test.sv]
// ----------------------------------------------------------------------------
// cursor_line_editor_test
// Self-checking bench for the two-stack line editor. Edit and dump commands
// are sent through the start/busy handshake. Every accepted item also updates
// a local copy of both stacks, and each dump there queues the characters it
// should stream out. A monitor compares each strobed result with the oldest
// queued character, field by field. Directed edge cases come first, then a
// buffer fill to capacity, then random edits in grow and shrink runs under
// three sender idle settings.
// ----------------------------------------------------------------------------
module cursor_line_editor_test;
   timeunit 1ns;
   timeprecision 1ps;
   import cle_pkg::*;

   localparam int TEXT_CAP = CAPACITY_DEFAULT;
   localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [2:0] KIND_SPARE_LAST = 3'd7;
   localparam int HALF_PERIOD = 2;
   localparam int RESET_CYCLES = 3;
   localparam int DRAIN_CYCLES = (QUEUE_DEPTH + 2) * (TEXT_CAP + 2);
   localparam int DRAIN_LIMIT = 20 * DRAIN_CYCLES;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 28;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // local copy of the text
   logic [7:0] left_chars[TEXT_CAP];
   logic [7:0] right_chars[TEXT_CAP];
   logic [6:0] left_len = '0;
   logic [6:0] right_len = '0;
   rsp_type    pending_chars[$];

   int error_count = 0;
   int cycle_count = 0;
   int idle_pct = 0;

   cursor_line_editor #(
      .CAPACITY(TEXT_CAP)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("cursor_line_editor verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [7:0] want_val,
                                  input logic [7:0] got_val);
      $display("%0t ns: %s mismatch, expected %h, got %h", $realtime, what, want_val,
               got_val);
      error_count++;
   endtask

   // queue one streamed character of a dump
   function automatic void queue_char(input logic [7:0] ch, input logic valid,
                                      input logic fin);
      rsp_type r;
      r.text_char = ch;
      r.nonempty = valid;
      r.last = fin;
      pending_chars.push_back(r);
   endfunction

   // update the local text for one accepted command
   function automatic void apply_command(input req_type item);
      int total;
      int n;
      case (item.kind)
         KIND_LEFT: begin
            if (left_len > 0 && right_len < TEXT_CAP) begin
               left_len--;
               right_chars[right_len] = left_chars[left_len];
               right_len++;
            end
         end
         KIND_RIGHT: begin
            if (right_len > 0 && left_len < TEXT_CAP) begin
               right_len--;
               left_chars[left_len] = right_chars[right_len];
               left_len++;
            end
         end
         KIND_BACK: begin
            if (left_len > 0) left_len--;
         end
         KIND_INSERT: begin
            if (int'(left_len) + int'(right_len) < TEXT_CAP) begin
               left_chars[left_len] = item.symbol;
               left_len++;
            end
         end
         KIND_DUMP: begin
            total = int'(left_len) + int'(right_len);
            n = 0;
            if (total == 0) begin
               queue_char(8'h00, 1'b0, 1'b1);
            end else begin
               for (int i = 0; i < left_len; i++) begin
                  n++;
                  queue_char(left_chars[i], 1'b1, n == total);
               end
               for (int i = int'(right_len); i > 0; i--) begin
                  n++;
                  queue_char(right_chars[i - 1], 1'b1, n == total);
               end
            end
         end
         default: ;
      endcase
   endfunction

   // send one command item, idling first at random
   task automatic issue_command(input logic [2:0] kind, input logic [7:0] sym);
      req_type item;
      item.kind = kind;
      item.symbol = sym;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      apply_command(item);
   endtask

   // result check
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_chars.size() == 0) begin
            report_mismatch("unexpected result, text_char", 8'h00, rsp_data.text_char);
         end else begin
            want = pending_chars.pop_front();
            if (rsp_data.text_char !== want.text_char)
               report_mismatch("text_char", want.text_char, rsp_data.text_char);
            if (rsp_data.nonempty !== want.nonempty)
               report_mismatch("nonempty", 8'(want.nonempty), 8'(rsp_data.nonempty));
            if (rsp_data.last !== want.last)
               report_mismatch("last", 8'(want.last), 8'(rsp_data.last));
         end
      end
   end

   // empty text: moves and backspace do nothing, spare codes are ignored
   task automatic test_empty_text;
      issue_command(KIND_DUMP, 8'($urandom_range(255)));
      issue_command(KIND_LEFT, 8'($urandom_range(255)));
      issue_command(KIND_RIGHT, 8'($urandom_range(255)));
      issue_command(KIND_BACK, 8'($urandom_range(255)));
      for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
         issue_command(3'(k), 8'($urandom_range(255)));
      issue_command(KIND_DUMP, 8'($urandom_range(255)));
   endtask

   // extreme characters, edits in the middle, cursor walked to the start
   task automatic test_basic_edits;
      issue_command(KIND_INSERT, 8'h00);
      issue_command(KIND_INSERT, 8'hFF);
      issue_command(KIND_INSERT, 8'h80);
      issue_command(KIND_INSERT, 8'h7F);
      issue_command(KIND_DUMP, 8'h00);
      issue_command(KIND_LEFT, 8'h00);
      issue_command(KIND_LEFT, 8'h00);
      issue_command(KIND_INSERT, 8'h55);
      issue_command(KIND_RIGHT, 8'h00);
      issue_command(KIND_BACK, 8'h00);
      issue_command(KIND_DUMP, 8'h00);
      // three real moves, then one at the start
      repeat (4) issue_command(KIND_LEFT, 8'hAA);
      issue_command(KIND_BACK, 8'h00);
      issue_command(KIND_DUMP, 8'h00);
   endtask

   // fill to capacity, drop inserts, then empty the text again
   task automatic test_full_text;
      while (int'(left_len) + int'(right_len) < TEXT_CAP)
         issue_command(KIND_INSERT, 8'($urandom_range(255)));
      repeat (2) issue_command(KIND_INSERT, 8'($urandom_range(255)));
      issue_command(KIND_RIGHT, 8'h00);
      issue_command(KIND_DUMP, 8'h00);
      repeat (3) issue_command(KIND_LEFT, 8'h00);
      issue_command(KIND_INSERT, 8'($urandom_range(255)));
      issue_command(KIND_DUMP, 8'h00);
      while (left_len > 0) issue_command(KIND_BACK, 8'($urandom_range(255)));
      issue_command(KIND_LEFT, 8'h00);
      issue_command(KIND_DUMP, 8'h00);
      repeat (4) issue_command(KIND_RIGHT, 8'h00);
      while (left_len > 0) issue_command(KIND_BACK, 8'h00);
      issue_command(KIND_DUMP, 8'h00);
   endtask

   // random edits in runs that grow or shrink the text
   task automatic test_random_edits(input int pct, input int count);
      int         sent;
      int         run_left;
      bit         grow;
      int         r;
      logic [2:0] kind;
      idle_pct = pct;
      sent = 0;
      run_left = 0;
      grow = 1'b1;
      while (sent < count) begin
         if (run_left == 0) begin
            run_left = $urandom_range(40, 10);
            grow = (left_len + right_len < TEXT_CAP / 4) ? 1'b1 : 1'($urandom_range(1));
         end
         run_left--;
         r = $urandom_range(99);
         if (grow) begin
            if (r < 45) kind = KIND_INSERT;
            else if (r < 60) kind = KIND_LEFT;
            else if (r < 75) kind = KIND_RIGHT;
            else if (r < 83) kind = KIND_BACK;
            else if (r < 94) kind = KIND_DUMP;
            else kind = 3'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
         end else begin
            if (r < 12) kind = KIND_INSERT;
            else if (r < 32) kind = KIND_LEFT;
            else if (r < 47) kind = KIND_RIGHT;
            else if (r < 80) kind = KIND_BACK;
            else if (r < 94) kind = KIND_DUMP;
            else kind = 3'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
         end
         issue_command(kind, 8'($urandom_range(255)));
         if (kind <= KIND_DUMP) sent++;
      end
   endtask

   // stop sending and let every dump finish
   task automatic wait_drained;
      int waited;
      @(negedge clock);
      start <= 1'b0;
      waited = 0;
      while (pending_chars.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_chars.size() != 0)
         report_mismatch("characters never streamed, count", 8'h00,
                         8'(pending_chars.size()));
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_pct = 35;
      test_empty_text();
      test_basic_edits();
      test_full_text();
      test_random_edits(35, RANDOM_ITEMS);
      test_random_edits(74, RANDOM_ITEMS);
      test_random_edits(0, RANDOM_ITEMS);
      wait_drained();
      if (error_count == 0) begin
         $display("cursor_line_editor verification clean");
      end else begin
         $display("cursor_line_editor verification failed");
      end
      $finish;
   end

endmodule
